>>> sv/mts_pkg.sv
// Shared types and constants for the max-tracking stack.
package mts_pkg;

    localparam int MTS_DEPTH = 128;
    localparam int MTS_DATA_W = 32;
    localparam int MTS_COUNT_W = 8;

    // Maximum reported by an empty store.
    localparam logic signed [MTS_DATA_W-1:0] MTS_MAX_FLOOR = -32'sd2147483647;

    localparam logic MTS_OP_PUSH = 1'b0;
    localparam logic MTS_OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2
    } mts_status_t;

    typedef struct packed {
        logic                         operation;
        logic signed [MTS_DATA_W-1:0] value;
    } mts_req_t;

    typedef struct packed {
        logic signed [MTS_DATA_W-1:0] read_value;
        logic signed [MTS_DATA_W-1:0] max_value;
        logic [MTS_COUNT_W-1:0]       entry_count;
        mts_status_t                  status;
    } mts_rsp_t;

endpackage

>>> sv/max_tracking_stack_unit.sv
// Top level of the max-tracking stack: sequencer, running maximum and result register.
//
// A last-in first-out store of signed 32-bit values that also reports the
// largest value it holds. Each request item is a push or a pop and yields
// exactly one response item carrying the popped value (0 on push or error),
// the maximum after the step (-2147483647 when empty), the entry count (low
// 8 bits) and a status code (ok, push on full, pop on empty; an error leaves
// the state as it was). Entries live in one RAM with a registered read,
// and that single read port sets the timing: a push, or any error, is
// answered from the idle state; a pop reads the top entry, then responds;
// a pop that removes the current maximum rescans the remaining N entries
// from the bottom, one RAM read per cycle, before it responds.
// The next request is taken once the sequencer is idle and the output
// register is free, or at the edge at which the consumer takes the response
// it holds; a response held by a stalled consumer holds the input off. RAM
// writes happen only on an accepted push and reads only during a pop, so a
// read never meets a write to the same entry in the same cycle.
module max_tracking_stack_unit
    import mts_pkg::*;
#(
    parameter int DEPTH = MTS_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  mts_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output mts_rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                fill_reg, fill_next;
    logic signed [MTS_DATA_W-1:0] max_reg, max_next;
    logic [CW-1:0]                scan_idx_reg, scan_idx_next;
    logic signed [MTS_DATA_W-1:0] scan_max_reg, scan_max_next;
    logic signed [MTS_DATA_W-1:0] pop_val_reg, pop_val_next;
    logic                         out_valid_reg, out_valid_next;
    mts_rsp_t                     out_reg, out_next;

    logic                         wr_en;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [MTS_DATA_W-1:0]        rd_data;
    logic signed [MTS_DATA_W-1:0] rd_value;
    logic [CW-1:0]                fill_dec;
    logic signed [MTS_DATA_W-1:0] scan_cand;
    logic                         accept;
    logic                         out_busy;

    mts_ram #(
        .WIDTH (MTS_DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_value = rd_data;
    assign fill_dec = fill_reg - CW'(1);

    // Output slot stays occupied while the consumer stalls.
    assign out_busy  = out_valid_reg && rsp_stall;
    assign req_stall = (state_reg != S_IDLE) || out_busy;
    assign accept    = req_valid && !req_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Running candidate of the rescan: fold in the entry read last cycle.
    assign scan_cand = (rd_value > scan_max_reg) ? rd_value : scan_max_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        max_next       = max_reg;
        scan_idx_next  = scan_idx_reg;
        scan_max_next  = scan_max_reg;
        pop_val_next   = pop_val_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        // Drop the response once the consumer takes it.
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == MTS_OP_PUSH)
                    begin
                        out_next.read_value = '0;
                        if (fill_reg == CW'(DEPTH))
                        begin
                            out_next.max_value   = max_reg;
                            out_next.entry_count = MTS_COUNT_W'(fill_reg);
                            out_next.status      = ST_PUSH_FULL;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + CW'(1);
                            max_next  = (req.value > max_reg) ? req.value : max_reg;
                            out_next.max_value   = max_next;
                            out_next.entry_count = MTS_COUNT_W'(fill_next);
                            out_next.status      = ST_OK;
                        end
                        out_valid_next = 1'b1;
                    end
                    else if (fill_reg == '0)
                    begin
                        out_next.read_value  = '0;
                        out_next.max_value   = max_reg;
                        out_next.entry_count = MTS_COUNT_W'(fill_reg);
                        out_next.status      = ST_POP_EMPTY;
                        out_valid_next       = 1'b1;
                    end
                    else
                    begin
                        // Fetch the top entry.
                        rd_en      = 1'b1;
                        rd_addr    = fill_dec[AW-1:0];
                        fill_next  = fill_dec;
                        state_next = S_POP;
                    end
                end
            end

            S_POP:
            begin
                pop_val_next = rd_value;
                if ((rd_value == max_reg) && (fill_reg != '0))
                begin
                    // Popped the maximum: rescan from the bottom.
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    scan_idx_next = CW'(1);
                    scan_max_next = MTS_MAX_FLOOR;
                    state_next    = S_SCAN;
                end
                else
                begin
                    if (rd_value == max_reg)
                    begin
                        max_next = MTS_MAX_FLOOR;
                    end
                    out_next.read_value  = rd_value;
                    out_next.max_value   = max_next;
                    out_next.entry_count = MTS_COUNT_W'(fill_reg);
                    out_next.status      = ST_OK;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (scan_idx_reg == fill_reg)
                begin
                    max_next             = scan_cand;
                    out_next.read_value  = pop_val_reg;
                    out_next.max_value   = scan_cand;
                    out_next.entry_count = MTS_COUNT_W'(fill_reg);
                    out_next.status      = ST_OK;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                    scan_max_next = scan_cand;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            max_reg       <= MTS_MAX_FLOOR;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            max_reg       <= max_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        scan_max_reg <= scan_max_next;
        pop_val_reg  <= pop_val_next;
        out_reg      <= out_next;
    end

endmodule

>>> sv/mts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mts_ram
    import mts_pkg::*;
#(
    parameter int WIDTH = MTS_DATA_W,
    parameter int DEPTH = MTS_DEPTH
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> tb/max_stack_score_pkg.sv
// Scoreboard class for the max-tracking stack: shadow stack, running maximum and result checks.
package max_stack_score_pkg;

    import mts_pkg::*;

    class max_stack_scoreboard;
        logic signed [MTS_DATA_W-1:0] shadow_stack[$];
        logic signed [MTS_DATA_W-1:0] shadow_max;
        mts_rsp_t                     due_results[$];
        int mismatches;
        int checked;
        int pushes;
        int pops;
        int full_pushes;
        int empty_pops;
        int rescans;

        function new();
            shadow_max  = MTS_MAX_FLOOR;
            mismatches  = 0;
            checked     = 0;
            pushes      = 0;
            pops        = 0;
            full_pushes = 0;
            empty_pops  = 0;
            rescans     = 0;
        endfunction

        // Advance the shadow stack by one accepted item and queue the result it owes.
        function void note_request(mts_req_t item);
            mts_rsp_t                     want;
            logic signed [MTS_DATA_W-1:0] v;
            logic signed [MTS_DATA_W-1:0] top;
            v = item.value;
            want.read_value = '0;
            want.status     = ST_OK;
            if (item.operation == MTS_OP_PUSH)
            begin
                pushes++;
                if (shadow_stack.size() >= MTS_DEPTH)
                begin
                    want.status = ST_PUSH_FULL;
                    full_pushes++;
                end
                else
                begin
                    if (v > shadow_max)
                        shadow_max = v;
                    shadow_stack.push_back(v);
                end
            end
            else
            begin
                pops++;
                if (shadow_stack.size() == 0)
                begin
                    want.status = ST_POP_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    top = shadow_stack.pop_back();
                    want.read_value = top;
                    // Popping the maximum: rescan what is left, starting at the floor.
                    if (top == shadow_max)
                    begin
                        rescans++;
                        shadow_max = MTS_MAX_FLOOR;
                        foreach (shadow_stack[i])
                            if (shadow_stack[i] > shadow_max)
                                shadow_max = shadow_stack[i];
                    end
                end
            end
            want.max_value   = shadow_max;
            want.entry_count = MTS_COUNT_W'(shadow_stack.size());
            due_results.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
            mismatches++;
            if (mismatches <= 100)
                $display("tb: mismatch at result %0d, %s: got %0d, want %0d",
                         checked, what, $signed(got_v), $signed(want_v));
        endtask

        // Compare one accepted result with the oldest one owed.
        task check_result(mts_rsp_t got);
            mts_rsp_t want;
            checked++;
            if (due_results.size() == 0)
            begin
                report_mismatch("result with none owed", got.read_value, '0);
                return;
            end
            want = due_results.pop_front();
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", got.read_value, want.read_value);
            if (got.max_value !== want.max_value)
                report_mismatch("max_value", got.max_value, want.max_value);
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        endtask

        function int owed();
            return due_results.size();
        endfunction
    endclass

endpackage

>>> tb/tb.sv
// Self-checking testbench for the max-tracking stack unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;
    import max_stack_score_pkg::*;

    // Run length and pacing.
    localparam int ITEM_TARGET   = 1150;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    // A pop of the maximum rescans up to DEPTH - 1 entries before its result.
    localparam int SETTLE_CYCLES = MTS_DEPTH + 20;

    typedef enum int { SEG_FILL, SEG_DRAIN, SEG_MIXED } seg_kind_t;

    // Idle and stall rates per phase: none, sender only, receiver only, both.
    localparam int SEND_IDLE_PCT[4] = '{0, 64, 0, 28};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 64, 28};

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    mts_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    mts_rsp_t rsp;

    max_stack_scoreboard sb;

    // Pacing knobs, written by the stimulus process only.
    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_pending = 1'b0;

    // Stimulus-side bookkeeping.
    int level = 0;
    int sent_count = 0;
    int cycle_count = 0;
    logic signed [MTS_DATA_W-1:0] last_push = '0;

    max_tracking_stack_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Monitor both channels at the edge; values seen here are the pre-edge ones.
    // Check the result first: a result leaving at this edge belongs to an older item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp);
            if (req_valid && !req_stall)
                sb.note_request(req);
        end
    end

    // Receiver: stall at random per phase, and once hold off for a long stretch
    // so the output register stays full and the block backs up onto its input.
    initial
    begin
        bit held_once;
        int hold_left;
        held_once = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_pending && !held_once)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic void set_phase(input int idx);
        idle_pct  = SEND_IDLE_PCT[idx % 4];
        stall_pct = RECV_STALL_PCT[idx % 4];
    endfunction

    // Mix of full-range values, small values that collide with the maximum,
    // extremes, and a rising ramp that makes later pops remove the maximum.
    function automatic logic signed [MTS_DATA_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return $urandom;
        if (roll < 70)
            return $signed(32'($urandom_range(40))) - 32'sd20;
        if (roll < 80)
        begin
            case ($urandom_range(2))
                0:       return 32'sh7fffffff;
                1:       return MTS_MAX_FLOOR;
                default: return 32'sh80000000;
            endcase
        end
        return last_push + $urandom_range(1, 1000);
    endfunction

    // Offer one item: idle first as the phase says, then hold it until taken.
    // Called at a rising edge; valid gets exactly one assignment per edge.
    task automatic send_item(input logic op, input logic signed [MTS_DATA_W-1:0] v);
        mts_req_t item;
        item.operation = op;
        item.value     = v;
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (op == MTS_OP_PUSH)
        begin
            if (level < MTS_DEPTH)
                level++;
            last_push = v;
        end
        else if (level > 0)
        begin
            level--;
        end
        sent_count++;
    endtask

    task automatic push_item(input logic signed [MTS_DATA_W-1:0] v);
        send_item(MTS_OP_PUSH, v);
    endtask

    // The value field of a pop is ignored; drive noise into it anyway.
    task automatic pop_item();
        send_item(MTS_OP_POP, $urandom);
    endtask

    task automatic run_segment(input seg_kind_t kind, input int length);
        int push_pct;
        push_pct = $urandom_range(40, 65);
        case (kind)
            SEG_FILL:
            begin
                // Fill to the top, then push into the full store a few times.
                while (level < MTS_DEPTH)
                    push_item(pick_value());
                repeat ($urandom_range(1, 4))
                    push_item(pick_value());
            end
            SEG_DRAIN:
            begin
                // Empty the store, then pop it while empty.
                while (level > 0)
                    pop_item();
                repeat ($urandom_range(1, 3))
                    pop_item();
            end
            default:
            begin
                repeat (length)
                begin
                    if ($urandom_range(99) < push_pct)
                        push_item(pick_value());
                    else
                        pop_item();
                end
            end
        endcase
    endtask

    // Stimulus: reset, directed corners, random segments, pressure, drain, verdict.
    initial
    begin
        int seg;
        int pick;
        bit pressured;
        seg = 0;
        pressured = 1'b0;
        sb = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed part, no idling.
        set_phase(0);
        pop_item();                     // pop on empty store
        push_item(32'sh80000000);       // below the floor: stored but cannot raise the max
        pop_item();
        push_item(32'sh7fffffff);
        push_item(MTS_MAX_FLOOR);
        push_item(32'sd0);
        push_item(-32'sd1);
        push_item(32'sh55555555);
        push_item(32'sh7fffffff);       // duplicate of the maximum
        pop_item();                     // rescan finds the other copy
        pop_item();
        pop_item();
        pop_item();
        pop_item();
        pop_item();                     // last maximum goes, store empties
        pop_item();
        push_item(MTS_MAX_FLOOR);       // equal to the floor
        push_item(32'sh80000000);
        pop_item();
        pop_item();                     // pop of the floor value with rescan of nothing
        push_item(32'shaaaaaaaa);
        push_item(32'sh55555555);
        pop_item();
        pop_item();

        // Random part: fill and drain once early, then random fill, drain and mixed segments.
        while (sent_count < ITEM_TARGET)
        begin
            set_phase(seg);
            if (seg == 0)
            begin
                run_segment(SEG_FILL, 0);
            end
            else if (seg == 1)
            begin
                run_segment(SEG_DRAIN, 0);
            end
            else if (!pressured && sent_count > ITEM_TARGET / 2)
            begin
                // Hold the receiver off while the sender keeps offering items.
                pressured = 1'b1;
                set_phase(0);
                hold_pending = 1'b1;
                run_segment(SEG_MIXED, 40);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                    run_segment(SEG_FILL, 0);
                else if (pick < 30)
                    run_segment(SEG_DRAIN, 0);
                else
                    run_segment(SEG_MIXED, $urandom_range(20, 80));
            end
            seg++;
        end
        req_valid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays.
        set_phase(0);
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d items: %0d pushes (%0d on a full store), %0d pops (%0d on empty)",
                 sent_count, sb.pushes, sb.full_pushes, sb.pops, sb.empty_pops);
        $display("tb: %0d pops of the maximum rescanned; %0d results checked, %0d mismatches",
                 sb.rescans, sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
